// ----- design/bpf4_pkg.sv -----
// Shared types and constants of the fourth-order bandpass cascade.
`timescale 1ns / 1ps
`default_nettype none
package bpf4_pkg;

	// Width of the operand chunk index; it can address up to four chunks.
	localparam int CHUNK_W = 2;
	// Width of the active section count (up to fifteen sections).
	localparam int NSEC_W  = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_FB,
		ST_FB_DRAIN,
		ST_W0,
		ST_GAIN,
		ST_GAIN_DRAIN,
		ST_Y,
		ST_DONE
	} bpf4_state_t;

	typedef struct packed {
		logic               take_item;
		logic               mem_rd;
		logic               load_row;
		logic               acc_clr;
		logic               mul_en;
		logic               mul_gain;
		logic [1:0]         term;
		logic [CHUNK_W-1:0] chunk;
		logic               w0_en;
		logic               y_en;
		logic               out_wr;
	} bpf4_cmd_t;

	typedef struct packed {
		logic              is_load;
		logic [NSEC_W-1:0] n_sec;
		logic              out_free;
	} bpf4_status_t;

endpackage
`default_nettype wire

// ----- design/bpf4_req_if.sv -----
// Request and result channel interfaces of the bandpass cascade.
`timescale 1ns / 1ps
`default_nettype none
interface bpf4_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [15:0] sample_in;
	logic               end_of_block;
	logic [2:0]         coef_section;
	logic [2:0]         coef_slot;
	logic signed [31:0] coef_value;

	modport source (output valid, req_type, sample_in, end_of_block, coef_section,
		coef_slot, coef_value, input ready);
	modport sink (input valid, req_type, sample_in, end_of_block, coef_section,
		coef_slot, coef_value, output ready);
endinterface

interface bpf4_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               block_done;

	modport source (output valid, sample_out, block_done, input ready);
	modport sink (input valid, sample_out, block_done, output ready);
endinterface
`default_nettype wire

// ----- design/bpf4_ctrl.sv -----
// Sequencer that steps the shared multiply-accumulate datapath through each section.
`timescale 1ns / 1ps
`default_nettype none
module bpf4_ctrl import bpf4_pkg::*; #(
	parameter int SEC_W      = 3,
	parameter int NUM_CHUNKS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  bpf4_status_t       status,
	output bpf4_cmd_t          cmd,
	output logic [SEC_W-1:0]   sec
);

	localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(NUM_CHUNKS - 1);

	bpf4_state_t        state_q, state_d;
	logic [SEC_W-1:0]   sec_q, sec_d;
	logic [1:0]         term_q, term_d;
	logic [CHUNK_W-1:0] chunk_q, chunk_d;
	logic               last_sec;

	assign sec      = sec_q;
	assign last_sec = (NSEC_W'(sec_q) + NSEC_W'(1)) == status.n_sec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q   <= '0;
			term_q  <= '0;
			chunk_q <= '0;
		end else begin
			state_q <= state_d;
			sec_q   <= sec_d;
			term_q  <= term_d;
			chunk_q <= chunk_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		sec_d     = sec_q;
		term_d    = term_q;
		chunk_d   = chunk_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.term  = term_q;
		cmd.chunk = chunk_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take_item = 1'b1;
					sec_d         = '0;
					if (!status.is_load) begin
						state_d = (status.n_sec == '0) ? ST_DONE : ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_row = 1'b1;
				cmd.acc_clr  = 1'b1;
				term_d       = '0;
				chunk_d      = '0;
				state_d      = ST_FB;
			end
			ST_FB: begin
				cmd.mul_en = 1'b1;
				if (chunk_q == LAST_CHUNK) begin
					chunk_d = '0;
					term_d  = term_q + 2'd1;
					if (term_q == 2'd3) begin
						state_d = ST_FB_DRAIN;
					end
				end else begin
					chunk_d = chunk_q + CHUNK_W'(1);
				end
			end
			ST_FB_DRAIN: begin
				state_d = ST_W0;
			end
			ST_W0: begin
				cmd.w0_en   = 1'b1;
				cmd.acc_clr = 1'b1;
				chunk_d     = '0;
				state_d     = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_gain = 1'b1;
				if (chunk_q == LAST_CHUNK) begin
					chunk_d = '0;
					state_d = ST_GAIN_DRAIN;
				end else begin
					chunk_d = chunk_q + CHUNK_W'(1);
				end
			end
			ST_GAIN_DRAIN: begin
				state_d = ST_Y;
			end
			ST_Y: begin
				cmd.y_en = 1'b1;
				if (last_sec) begin
					state_d = ST_DONE;
				end else begin
					sec_d   = sec_q + SEC_W'(1);
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_wr = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/bpf4_dp.sv -----
// Datapath: coefficient and delay memories, chunked multiplier, accumulator and output register.
`timescale 1ns / 1ps
`default_nettype none
module bpf4_dp import bpf4_pkg::*; #(
	parameter int MAX_SECTIONS = 8,
	parameter int COEF_WIDTH   = 32,
	parameter int DELAY_WIDTH  = 56,
	parameter int SEC_W        = 3,
	parameter int NUM_CHUNKS   = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               req_type,
	input  logic signed [15:0] sample_in,
	input  logic               end_of_block,
	input  logic [2:0]         coef_section,
	input  logic [2:0]         coef_slot,
	input  logic signed [31:0] coef_value,
	input  bpf4_cmd_t          cmd,
	input  logic [SEC_W-1:0]   sec,
	output bpf4_status_t       status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out,
	output logic               block_done
);

	localparam int CF    = COEF_WIDTH - 4;
	localparam int OPW   = DELAY_WIDTH + 2;
	localparam int PADW  = NUM_CHUNKS * 32;
	localparam int ACC_W = COEF_WIDTH + DELAY_WIDTH + 5;
	localparam int PRW   = COEF_WIDTH + 33;
	localparam int K     = CF + 16;

	// Configuration register.
	logic [3:0] cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 4'd1;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	assign status.is_load  = req_type;
	assign status.n_sec    = ({1'b0, cfg_q} > NSEC_W'(MAX_SECTIONS)) ?
		NSEC_W'(MAX_SECTIONS) : {1'b0, cfg_q};
	assign status.out_free = !out_valid || out_ready;

	// Coefficient load path.
	logic signed [COEF_WIDTH-1:0] coef_scaled;
	logic [NSEC_W-1:0]            ld_sec;
	logic                         ld_ok;

	generate
		if (COEF_WIDTH >= 32) begin : g_coef_up
			assign coef_scaled = COEF_WIDTH'(coef_value) <<< (COEF_WIDTH - 32);
		end else begin : g_coef_dn
			assign coef_scaled = COEF_WIDTH'(coef_value >>> (32 - COEF_WIDTH));
		end
	endgenerate

	assign ld_sec = NSEC_W'(coef_section);
	assign ld_ok  = cmd.take_item && req_type && (coef_slot <= 3'd4) &&
		(ld_sec < NSEC_W'(MAX_SECTIONS));

	logic [COEF_WIDTH-1:0]               coef_mem [MAX_SECTIONS][5];
	logic [MAX_SECTIONS-1:0][4:0]        coef_vld_q;
	logic [COEF_WIDTH-1:0]               coef_rd_s1 [5];
	logic [4:0]                          coef_vld_s1;

	always_ff @(posedge clk) begin
		if (ld_ok) begin
			coef_mem[ld_sec[SEC_W-1:0]][coef_slot] <= coef_scaled;
		end
		if (cmd.mem_rd) begin
			coef_rd_s1 <= coef_mem[sec];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q  <= '0;
			coef_vld_s1 <= '0;
		end else begin
			if (ld_ok) begin
				coef_vld_q[ld_sec[SEC_W-1:0]][coef_slot] <= 1'b1;
			end
			if (cmd.mem_rd) begin
				coef_vld_s1 <= coef_vld_q[sec];
			end
		end
	end

	// Working registers of the current section.
	logic signed [COEF_WIDTH-1:0]  c_q [5];
	logic signed [DELAY_WIDTH-1:0] w_q [4];
	logic signed [OPW-1:0]         t_q;
	logic signed [15:0]            x_q;
	logic                          eob_q;
	logic signed [15:0]            y_sat;

	// Delay memory: one row of four delays per section.
	logic [4*DELAY_WIDTH-1:0] dly_mem [MAX_SECTIONS];
	logic [MAX_SECTIONS-1:0]  dly_vld_q;
	logic [4*DELAY_WIDTH-1:0] dly_rd_s1;
	logic                     dly_vld_s1;
	logic signed [DELAY_WIDTH-1:0] w0;

	always_ff @(posedge clk) begin
		if (cmd.w0_en) begin
			dly_mem[sec] <= {w_q[2], w_q[1], w_q[0], w0};
		end
		if (cmd.mem_rd) begin
			dly_rd_s1 <= dly_mem[sec];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_vld_q  <= '0;
			dly_vld_s1 <= 1'b0;
		end else begin
			if (cmd.out_wr && eob_q) begin
				dly_vld_q <= '0;
			end else if (cmd.w0_en) begin
				dly_vld_q[sec] <= 1'b1;
			end
			if (cmd.mem_rd) begin
				dly_vld_s1 <= dly_vld_q[sec];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_row) begin
			for (int i = 0; i < 5; i++) begin
				c_q[i] <= coef_vld_s1[i] ? coef_rd_s1[i] : '0;
			end
			for (int i = 0; i < 4; i++) begin
				w_q[i] <= dly_vld_s1 ? dly_rd_s1[i*DELAY_WIDTH +: DELAY_WIDTH] : '0;
			end
		end
		if (cmd.w0_en) begin
			t_q <= OPW'(w0) - (OPW'(w_q[1]) <<< 1) + OPW'(w_q[3]);
		end
		if (cmd.take_item) begin
			x_q   <= sample_in;
			eob_q <= end_of_block;
		end else if (cmd.y_en) begin
			x_q <= y_sat;
		end
	end

	// Multiplier: coefficient times one 32-bit chunk of the operand per cycle.
	logic signed [COEF_WIDTH-1:0] coef_sel;
	logic signed [OPW-1:0]        op_sel;
	logic signed [PADW-1:0]       op_pad;
	logic [31:0]                  op_chunk;
	logic signed [32:0]           mul_b;
	logic signed [PRW-1:0]        prod_s1;
	logic [CHUNK_W-1:0]           chunk_s1;
	logic                         pvld_s1;

	assign coef_sel = cmd.mul_gain ? c_q[0] : c_q[3'({1'b0, cmd.term}) + 3'd1];
	assign op_sel   = cmd.mul_gain ? t_q : OPW'(w_q[cmd.term]);
	assign op_pad   = PADW'(op_sel);
	assign op_chunk = op_pad[cmd.chunk*32 +: 32];
	// Only the top chunk carries the sign; the lower ones are unsigned.
	assign mul_b    = {(cmd.chunk == CHUNK_W'(NUM_CHUNKS - 1)) ? op_chunk[31] : 1'b0,
		op_chunk};

	always_ff @(posedge clk) begin
		prod_s1  <= coef_sel * mul_b;
		chunk_s1 <= cmd.chunk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_s1 <= 1'b0;
		end else begin
			pvld_s1 <= cmd.mul_en;
		end
	end

	// Accumulator.
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] pp_ext;

	assign pp_ext = ACC_W'(prod_s1) <<< (32 * chunk_s1);

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (pvld_s1) begin
			acc_q <= acc_q + pp_ext;
		end
	end

	// New delay value, saturated to the delay width.
	logic signed [ACC_W-1:0] w0_sum;
	logic signed [ACC_W-1:0] dmax_ext;
	logic signed [ACC_W-1:0] dmin_ext;

	assign dmax_ext = ACC_W'($signed({1'b0, {(DELAY_WIDTH-1){1'b1}}}));
	assign dmin_ext = ~dmax_ext;
	assign w0_sum   = (acc_q >>> CF) + (ACC_W'(x_q) <<< 16);
	assign w0 = (w0_sum > dmax_ext) ? DELAY_WIDTH'(dmax_ext) :
		(w0_sum < dmin_ext) ? DELAY_WIDTH'(dmin_ext) : DELAY_WIDTH'(w0_sum);

	// Section output, truncated toward zero and saturated to 16 bits.
	logic [ACC_W-1:0]        rnd_c;
	logic signed [ACC_W-1:0] y_rnd;
	logic signed [ACC_W-1:0] y_sh;

	assign rnd_c = {{(ACC_W-K){1'b0}}, {K{1'b1}}};
	assign y_rnd = acc_q + (acc_q[ACC_W-1] ? $signed(rnd_c) : '0);
	assign y_sh  = y_rnd >>> K;
	assign y_sat = (y_sh > ACC_W'(32767)) ? 16'sd32767 :
		(y_sh < -ACC_W'(32768)) ? -16'sd32768 : 16'(y_sh);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_wr) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			sample_out <= x_q;
			block_done <= eob_q;
		end
	end

endmodule
`default_nettype wire

// ----- design/bandpass_fourth_order_cascade.sv -----
// Top level of the fourth-order bandpass filter cascade.
// The req channel carries either a sample to filter or a coefficient word to load;
// the rsp channel returns one filtered sample per sample beat, none per load beat.
// A load beat with a valid slot and section is written to coefficient memory at once.
// A sample beat runs each active section through one shared multiplier that works
// on 32-bit operand chunks, C = ceil((DELAY_WIDTH+2)/32) of them: a section reads
// its row, multiplies the four feedback terms and then the gain term chunk by chunk,
// and stores the new delay and the section output. With zero sections in use the
// sample is returned unchanged. The result waits in an output register; the next
// beat is accepted while it waits, and only the hand-off of the following result
// stalls on the receiver. The sections_in_use register (cfg_we, cfg_wdata) must be
// written between samples by the user; the block does not enforce this. Reset clears
// the coefficients, delays and output valid, and sets one section. Delays of all
// sections are cleared after a beat marked as end of block.
`timescale 1ns / 1ps
`default_nettype none
module bandpass_fourth_order_cascade import bpf4_pkg::*; #(
	parameter int MAX_SECTIONS = 8,
	parameter int COEF_WIDTH   = 32,
	parameter int DELAY_WIDTH  = 56
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	bpf4_req_if.sink   req,
	bpf4_rsp_if.source rsp
);

	localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int NUM_CHUNKS = (DELAY_WIDTH + 2 + 31) / 32;

	bpf4_cmd_t        cmd;
	bpf4_status_t     status;
	logic [SEC_W-1:0] sec;

	bpf4_ctrl #(
		.SEC_W      (SEC_W),
		.NUM_CHUNKS (NUM_CHUNKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd),
		.sec       (sec)
	);

	bpf4_dp #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.COEF_WIDTH   (COEF_WIDTH),
		.DELAY_WIDTH  (DELAY_WIDTH),
		.SEC_W        (SEC_W),
		.NUM_CHUNKS   (NUM_CHUNKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_type     (req.req_type),
		.sample_in    (req.sample_in),
		.end_of_block (req.end_of_block),
		.coef_section (req.coef_section),
		.coef_slot    (req.coef_slot),
		.coef_value   (req.coef_value),
		.cmd          (cmd),
		.sec          (sec),
		.status       (status),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.sample_out   (rsp.sample_out),
		.block_done   (rsp.block_done)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb_bandpass_fourth_order_cascade.sv -----
// Self-checking testbench of the fourth-order bandpass cascade.
`timescale 1ns / 1ps
module tb_bandpass_fourth_order_cascade;
	import bpf4_pkg::*;

	localparam int NUM_SEC    = 8;
	localparam int COEF_FRAC  = 28;
	localparam int DLY_FRAC   = 16;
	localparam int RAND_ITEMS = 500;
	localparam int SETTLE     = 300;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_LOAD   = 1'b1;
	localparam logic [2:0] SLOT_GAIN = 3'd0;
	localparam logic [2:0] SLOT_D1   = 3'd1;
	localparam logic [2:0] SLOT_D2   = 3'd2;
	localparam logic [2:0] SLOT_D3   = 3'd3;
	localparam logic [2:0] SLOT_D4   = 3'd4;
	localparam logic [2:0] SLOT_BAD5 = 3'd5;
	localparam logic [2:0] SLOT_BAD7 = 3'd7;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic               kind;
		logic signed [15:0] smp;
		logic               eob;
		logic [2:0]         sec;
		logic [2:0]         slot;
		logic signed [31:0] val;
		bit                 set_cfg;
		logic [3:0]         cfg;
		bit                 typed;
		logic signed [15:0] want;
		logic               want_done;
	} stim_row_t;

	typedef struct {
		logic signed [15:0] smp;
		logic               done;
	} filt_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;

	bpf4_req_if req_ch();
	bpf4_rsp_if rsp_ch();

	bandpass_fourth_order_cascade dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req_ch), .rsp(rsp_ch)
	);

	always #10 clk = ~clk;

	// Shadow state of the filter.
	logic signed [31:0] coef_mem [5*NUM_SEC];
	logic signed [55:0] delay_mem [4*NUM_SEC];
	logic [3:0]         active_sec;

	filt_out_t pending_out [$];
	int  errs = 0;
	bit  quiet = 1'b0;
	int  hold_asked = 0;
	stim_row_t dir_rows [21];

	function automatic wide_t clamp(wide_t a, int bits);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (a > hi) return hi;
		if (a < lo) return lo;
		return a;
	endfunction

	function automatic logic signed [15:0] filter_sample(logic signed [15:0] x_in, logic eob);
		wide_t acc;
		logic signed [55:0] w0;
		logic signed [15:0] x;
		int n, cb, db;
		x = x_in;
		n = (active_sec > NUM_SEC) ? NUM_SEC : int'(active_sec);
		for (int s = 0; s < n; s++) begin
			cb = 5 * s;
			db = 4 * s;
			acc = wide_t'(coef_mem[cb+1]) * wide_t'(delay_mem[db])
				+ wide_t'(coef_mem[cb+2]) * wide_t'(delay_mem[db+1])
				+ wide_t'(coef_mem[cb+3]) * wide_t'(delay_mem[db+2])
				+ wide_t'(coef_mem[cb+4]) * wide_t'(delay_mem[db+3]);
			acc = acc >>> COEF_FRAC;
			acc = acc + (wide_t'(x) <<< DLY_FRAC);
			w0 = 56'(clamp(acc, 56));
			acc = wide_t'(coef_mem[cb]) * wide_t'(w0)
				- 2 * wide_t'(coef_mem[cb]) * wide_t'(delay_mem[db+1])
				+ wide_t'(coef_mem[cb]) * wide_t'(delay_mem[db+3]);
			// The shift rounds down, so negative sums are biased first to round toward zero.
			if (acc < 0) acc = acc + (wide_t'(1) <<< (COEF_FRAC + DLY_FRAC)) - 1;
			acc = acc >>> (COEF_FRAC + DLY_FRAC);
			delay_mem[db+3] = delay_mem[db+2];
			delay_mem[db+2] = delay_mem[db+1];
			delay_mem[db+1] = delay_mem[db];
			delay_mem[db]   = w0;
			x = 16'(clamp(acc, 16));
		end
		if (eob) foreach (delay_mem[i]) delay_mem[i] = '0;
		return x;
	endfunction

	task automatic wait_idle();
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_sections(logic [3:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		active_sec = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_beat(stim_row_t r);
		filt_out_t e;
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 8) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.req_type     = r.kind;
		req_ch.sample_in    = r.smp;
		req_ch.end_of_block = r.eob;
		req_ch.coef_section = r.sec;
		req_ch.coef_slot    = r.slot;
		req_ch.coef_value   = r.val;
		do @(posedge clk); while (!req_ch.ready);
		if (r.kind == REQ_LOAD) begin
			if (r.slot <= SLOT_D4) coef_mem[5*r.sec + r.slot] = r.val;
		end else begin
			e.smp  = filter_sample(r.smp, r.eob);
			e.done = r.eob;
			if (r.typed) begin
				e.smp  = r.want;
				e.done = r.want_done;
			end
			pending_out.push_back(e);
		end
	endtask

	function automatic logic signed [31:0] pick_coef();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(signed'(24'($urandom)));
			2: return 32'sh1000_0000 + 32'(signed'(20'($urandom)));
			default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		endcase
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t r;
		r = '{default: '0};
		r.eob = ($urandom_range(0, 19) == 0);
		r.sec = 3'($urandom);
		r.val = pick_coef();
		if ($urandom_range(0, 99) < 15) begin
			r.kind = REQ_LOAD;
			r.slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			r.smp = 16'($urandom);
		end else begin
			r.kind = REQ_SAMPLE;
			r.slot = 3'($urandom);
			case ($urandom_range(0, 9))
				0: r.smp = 16'sh7FFF;
				1: r.smp = 16'sh8000;
				2: r.smp = 16'(signed'(8'($urandom)));
				default: r.smp = 16'($urandom);
			endcase
		end
		return r;
	endfunction

	// Receiver: random back-pressure, plus long hold-offs when the sender asks.
	initial begin
		int seen, hold_left;
		seen = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != seen) begin
				seen = hold_asked;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = quiet || ($urandom_range(0, 99) >= 8);
			end
		end
	end

	always @(posedge clk) begin
		filt_out_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_out.size() == 0) begin
				$display("%0t: result beat with nothing expected: sample %0d done %0b",
					$time, rsp_ch.sample_out, rsp_ch.block_done);
				errs++;
			end else begin
				e = pending_out.pop_front();
				if (rsp_ch.sample_out !== e.smp || rsp_ch.block_done !== e.done) begin
					$display("%0t: mismatch: expected sample %0d done %0b, got %0d done %0b",
						$time, e.smp, e.done, rsp_ch.sample_out, rsp_ch.block_done);
					errs++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		stim_row_t r;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_SAMPLE;
		req_ch.sample_in = '0;
		req_ch.end_of_block = 1'b0;
		req_ch.coef_section = '0;
		req_ch.coef_slot = SLOT_GAIN;
		req_ch.coef_value = '0;
		foreach (coef_mem[i]) coef_mem[i] = '0;
		foreach (delay_mem[i]) delay_mem[i] = '0;
		active_sec = 4'd1;

		// kind, sample, eob, section, slot, value, cfg?, cfg, typed?, want, want_done
		dir_rows = '{
			'{REQ_SAMPLE, 16'sh7FFF, 1'b0, 3'd0, SLOT_GAIN, 32'sh0, 0, 4'd0, 1, 16'sd0, 1'b0},
			'{REQ_SAMPLE, 16'sh8000, 1'b1, 3'd7, SLOT_BAD7, 32'sh0, 0, 4'd0, 1, 16'sd0, 1'b1},
			'{REQ_SAMPLE, 16'sh8000, 1'b0, 3'd0, SLOT_GAIN, 32'sh0, 1, 4'd0, 1, 16'sh8000, 1'b0},
			'{REQ_SAMPLE, 16'sh7FFF, 1'b1, 3'd0, SLOT_GAIN, 32'sh0, 0, 4'd0, 1, 16'sh7FFF, 1'b1},
			'{REQ_LOAD, 16'sh0, 1'b0, 3'd0, SLOT_BAD5, 32'sh7FFF_FFFF, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_LOAD, 16'sh0, 1'b1, 3'd3, SLOT_BAD7, 32'sh8000_0000, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_LOAD, 16'sh0, 1'b0, 3'd0, SLOT_GAIN, 32'sh1000_0000, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_LOAD, 16'sh0, 1'b0, 3'd0, SLOT_D1, 32'sh7FFF_FFFF, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_LOAD, 16'sh0, 1'b0, 3'd0, SLOT_D2, 32'sh8000_0000, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_LOAD, 16'sh0, 1'b0, 3'd0, SLOT_D3, -32'sd1, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_LOAD, 16'sh0, 1'b0, 3'd0, SLOT_D4, 32'sh0, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_SAMPLE, 16'sh7FFF, 1'b0, 3'd0, SLOT_GAIN, 32'sh0, 1, 4'd1, 0, 16'sd0, 1'b0},
			'{REQ_SAMPLE, 16'sh8000, 1'b0, 3'd0, SLOT_GAIN, 32'sh0, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_SAMPLE, 16'sd1, 1'b0, 3'd0, SLOT_GAIN, 32'sh0, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_SAMPLE, 16'sd0, 1'b1, 3'd0, SLOT_GAIN, 32'sh0, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_LOAD, 16'sh0, 1'b0, 3'd7, SLOT_GAIN, 32'sh8000_0000, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_LOAD, 16'sh0, 1'b0, 3'd7, SLOT_D4, 32'sh7FFF_FFFF, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_SAMPLE, 16'sh7FFF, 1'b0, 3'd0, SLOT_GAIN, 32'sh0, 1, 4'd15, 0, 16'sd0, 1'b0},
			'{REQ_SAMPLE, 16'sh8000, 1'b1, 3'd0, SLOT_GAIN, 32'sh0, 0, 4'd0, 0, 16'sd0, 1'b0},
			'{REQ_SAMPLE, 16'sd12345, 1'b0, 3'd0, SLOT_GAIN, 32'sh0, 1, 4'd8, 0, 16'sd0, 1'b0},
			'{REQ_SAMPLE, -16'sd1, 1'b1, 3'd0, SLOT_GAIN, 32'sh0, 0, 4'd0, 0, 16'sd0, 1'b0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_cfg) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
				wait_idle();
				write_sections(dir_rows[i].cfg);
			end
			send_beat(dir_rows[i]);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// New section count every hundred beats, the extremes included.
			if (n % 100 == 0) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
				wait_idle();
				case (n / 100)
					0: write_sections(4'd2);
					1: write_sections(4'd8);
					2: write_sections(4'd0);
					3: write_sections(4'd15);
					default: write_sections(4'($urandom_range(1, 9)));
				endcase
			end
			quiet = (n >= 150 && n < 230);
			if (n == 60 || n == 320) hold_asked++;
			r = random_row();
			send_beat(r);
		end
		@(negedge clk);
		req_ch.valid = 1'b0;
		wait_idle();
		if (errs == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
